// ===== sv/cts_pkg.sv =====
package cts_pkg;

    // Scanner states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_ONE    = 4'b0010,
        ST_WORD   = 4'b0100,
        ST_SWITCH = 4'b1000
    } t_scan;

    // Result kinds
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Command status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_SYNTAX   = 2'd1;
    localparam logic [1:0] STAT_DRIVE    = 2'd2;
    localparam logic [1:0] STAT_OVERFLOW = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_TRACE     = 2'd0;
    localparam logic [1:0] CFG_DRIVE_MAP = 2'd1;
    localparam logic [1:0] CFG_BUF_LIMIT = 2'd2;
    localparam logic [1:0] CFG_TOK_LIMIT = 2'd3;

    localparam int CFG_DATA_W  = 26;
    localparam int RES_SLOTS   = 4;   // most results one character can cause
    localparam int RES_CNT_W   = 3;
    localparam int RES_IDX_W   = 2;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5a;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7a;
    localparam logic [7:0] CASE_GAP = 8'h20;

    // Reset values of the limits
    localparam logic [15:0] BUF_LIMIT_RST = 16'd256;
    localparam logic [7:0]  TOK_LIMIT_RST = 8'd64;

    // One result beat
    typedef struct packed {
        logic        kind;
        logic [7:0]  out_byte;
        logic [15:0] position;
        logic        token_ends;
        logic [15:0] token_start;
        logic [1:0]  status;
        logic [7:0]  token_count;
        logic        bad_valid;
        logic [7:0]  bad_index;
    } t_res;

endpackage

// ===== sv/command_line_token_splitter.sv =====
// Command-line token splitter.
// Input channel (i_in_valid / o_in_ready): one argument character per beat,
// NUL ends an argument, i_last marks the character that ends the command.
// Output channel (o_out_valid / i_out_ready): one result per beat, either a
// token buffer byte write (kind 0) or the final command status (kind 1);
// o_last_result flags the last result caused by a character.
// Config port: i_cfg_wr_en writes i_cfg_wdata into register i_cfg_index
// (0 trace mode, 1 drive map, 2 buffer limit, 3 token limit) at once.
// A character is scanned from the input buffer head into the result register.
// One character per cycle while each causes at most one result and the
// receiver is ready; further results hold the result register until taken.
// The output register holds all results of one character and is refilled in
// the cycle its last result is taken; a two-entry input buffer keeps
// o_in_ready off the combinational path from i_out_ready.
// When the receiver stalls, results hold, the input buffer fills and
// o_in_ready drops. Reset clears the scanner, the buffers and restores the
// register defaults (limits 256 bytes and 64 tokens).
module command_line_token_splitter import cts_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_ch,
    input  logic                  i_last,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_kind,
    output logic [7:0]            o_out_byte,
    output logic [15:0]           o_position,
    output logic                  o_token_ends,
    output logic [15:0]           o_token_start,
    output logic [1:0]            o_status,
    output logic [7:0]            o_token_count,
    output logic                  o_bad_token_valid,
    output logic [7:0]            o_bad_token_index,
    output logic                  o_last_result
);

    // Configuration registers
    logic        r_trace;
    logic [25:0] r_drive_map;
    logic [15:0] r_buf_limit;
    logic [7:0]  r_tok_limit;

    // Scanner state
    t_scan       r_scan;
    logic [7:0]  r_prev;
    logic [15:0] r_wp;
    logic [15:0] r_sp;
    logic [7:0]  r_tm;
    logic        r_syn;
    logic        r_drv;
    logic        r_badr;
    logic [7:0]  r_badi;
    logic        r_abt;

    // Input buffer: head and skid entry
    logic        r_hd_v;
    logic [7:0]  r_hd_ch;
    logic        r_hd_last;
    logic        r_sk_v;
    logic [7:0]  r_sk_ch;
    logic        r_sk_last;

    // Result register
    t_res                 r_res [RES_SLOTS];
    logic [RES_CNT_W-1:0] r_cnt;
    logic [RES_IDX_W-1:0] r_idx;

    // Next values from the scanner
    t_scan       n_scan;
    logic [7:0]  n_prev;
    logic [15:0] n_wp;
    logic [15:0] n_sp;
    logic [7:0]  n_tm;
    logic        n_syn;
    logic        n_drv;
    logic        n_badr;
    logic [7:0]  n_badi;
    logic        n_abt;
    t_res                 n_res [RES_SLOTS];
    logic [RES_CNT_W-1:0] n_cnt;

    logic accept;
    logic take;
    logic take_last;
    logic load;
    logic is_last_idx;

    // Handshakes
    assign o_in_ready  = !r_sk_v;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = (r_cnt != '0);
    assign is_last_idx = ({1'b0, r_idx} == (r_cnt - 1'b1));
    assign take        = o_out_valid && i_out_ready;
    assign take_last   = take && is_last_idx;
    assign load        = r_hd_v && (!o_out_valid || take_last);

    // Scanner: all work for the head character
    always_comb begin
        logic [7:0]  c;
        logic        tr;
        logic        ovf;
        logic        is_blank;
        logic        is_colon;
        logic        is_slash;
        logic        mid_tok;
        logic [7:0]  d;
        logic [7:0]  d_off;
        logic        drive_good;
        logic [RES_SLOTS-1:0] op_end;
        logic [RES_SLOTS-1:0] op_wr;
        t_scan       scan_nx;
        logic [16:0] wp_sum;
        logic [8:0]  tm_sum;

        c          = r_hd_ch;
        tr         = r_trace;
        n_scan     = r_scan;
        n_prev     = r_prev;
        n_wp       = r_wp;
        n_sp       = r_sp;
        n_tm       = r_tm;
        n_syn      = r_syn;
        n_drv      = r_drv;
        n_badr     = r_badr;
        n_badi     = r_badi;
        n_abt      = r_abt;
        n_cnt      = '0;
        op_end     = '0;
        op_wr      = '0;
        scan_nx    = r_scan;
        for (int k = 0; k < RES_SLOTS; k++) begin
            n_res[k] = '0;
        end

        wp_sum   = {1'b0, r_wp} + 17'd2;
        tm_sum   = {1'b0, r_tm} + 9'd2;
        ovf      = (wp_sum >= {1'b0, r_buf_limit}) || (tm_sum >= {1'b0, r_tok_limit});
        is_blank = (c == CH_NUL) || (c == CH_SPACE);
        is_colon = (c == CH_COLON) && !tr;
        is_slash = (c == CH_SLASH) && !tr;
        mid_tok  = (r_scan == ST_ONE) || (r_scan == ST_WORD);

        // Drive letter check on the character before the colon
        d = r_prev;
        if (d >= CH_LO_A && d <= CH_LO_Z) begin
            d = d - CASE_GAP;
        end
        d_off      = d - CH_UP_A;
        drive_good = (d >= CH_UP_A) && (d <= CH_UP_Z) && r_drive_map[d_off[4:0]];

        // Decode: slot 0 early end, slot 1 write, slot 2 end, slot 3 flush
        if (!r_abt) begin
            if (ovf) begin
                n_abt = 1'b1;
            end else begin
                n_prev = c;
                if (is_blank) begin
                    if (mid_tok) begin
                        op_end[2] = 1'b1;
                        scan_nx   = ST_IDLE;
                    end
                end else if (c == CH_COMMA) begin
                    if (mid_tok) begin
                        op_end[2] = 1'b1;
                        scan_nx   = ST_IDLE;
                    end else if (r_scan == ST_SWITCH) begin
                        n_syn     = 1'b1;
                        op_wr[1]  = 1'b1;
                        op_end[2] = 1'b1;
                        scan_nx   = ST_IDLE;
                    end
                end else if (is_colon) begin
                    op_wr[1]  = 1'b1;
                    op_end[2] = 1'b1;
                    scan_nx   = ST_IDLE;
                    if (r_scan == ST_ONE) begin
                        if (!drive_good) begin
                            n_drv = 1'b1;
                        end
                    end else begin
                        n_syn = 1'b1;
                    end
                end else if (is_slash) begin
                    case (r_scan)
                        ST_IDLE: begin
                            op_wr[1] = 1'b1;
                            scan_nx  = ST_SWITCH;
                        end
                        ST_WORD: begin
                            op_end[0] = 1'b1;
                            op_wr[1]  = 1'b1;
                            scan_nx   = ST_SWITCH;
                        end
                        ST_SWITCH: begin
                            n_syn     = 1'b1;
                            op_wr[1]  = 1'b1;
                            op_end[2] = 1'b1;
                            scan_nx   = ST_IDLE;
                        end
                        default: begin
                            scan_nx = r_scan;   // switch after one char: dropped
                        end
                    endcase
                end else begin
                    op_wr[1] = 1'b1;
                    scan_nx  = (r_scan == ST_IDLE) ? ST_ONE : ST_WORD;
                end
            end
        end
        n_scan = scan_nx;

        // Flush an open switch token at command end
        if (r_hd_last && !n_abt && (scan_nx == ST_SWITCH)) begin
            op_end[3] = 1'b1;
            n_scan    = ST_IDLE;
        end

        // Emit writes and token ends in order
        for (int k = 0; k < RES_SLOTS; k++) begin
            if (op_wr[k]) begin
                n_res[n_cnt[RES_IDX_W-1:0]].kind     = KIND_BYTE;
                n_res[n_cnt[RES_IDX_W-1:0]].out_byte = c;
                n_res[n_cnt[RES_IDX_W-1:0]].position = n_wp;
                n_cnt = n_cnt + 1'b1;
                n_wp  = n_wp + 16'd1;
            end
            if (op_end[k]) begin
                if (!n_badr && !n_syn && n_drv) begin
                    n_badi = n_tm;
                    n_badr = 1'b1;
                end
                n_res[n_cnt[RES_IDX_W-1:0]].kind        = KIND_BYTE;
                n_res[n_cnt[RES_IDX_W-1:0]].out_byte    = CH_NUL;
                n_res[n_cnt[RES_IDX_W-1:0]].position    = n_wp;
                n_res[n_cnt[RES_IDX_W-1:0]].token_ends  = 1'b1;
                n_res[n_cnt[RES_IDX_W-1:0]].token_start = n_sp;
                n_cnt = n_cnt + 1'b1;
                n_wp  = n_wp + 16'd1;
                n_tm  = n_tm + 8'd1;
                n_sp  = n_wp;
            end
        end

        // Command status, then clear for the next command
        if (r_hd_last) begin
            n_res[n_cnt[RES_IDX_W-1:0]].kind        = KIND_STATUS;
            n_res[n_cnt[RES_IDX_W-1:0]].status      = n_abt ? STAT_OVERFLOW :
                                                      n_syn ? STAT_SYNTAX :
                                                      n_drv ? STAT_DRIVE : STAT_OK;
            n_res[n_cnt[RES_IDX_W-1:0]].token_count = n_tm;
            n_res[n_cnt[RES_IDX_W-1:0]].bad_valid   = n_badr;
            n_res[n_cnt[RES_IDX_W-1:0]].bad_index   = n_badi;
            n_cnt  = n_cnt + 1'b1;
            n_scan = ST_IDLE;
            n_prev = CH_COMMA;
            n_wp   = '0;
            n_sp   = '0;
            n_tm   = '0;
            n_syn  = 1'b0;
            n_drv  = 1'b0;
            n_badr = 1'b0;
            n_badi = '0;
            n_abt  = 1'b0;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trace     <= 1'b0;
            r_drive_map <= '0;
            r_buf_limit <= BUF_LIMIT_RST;
            r_tok_limit <= TOK_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_TRACE:     r_trace     <= i_cfg_wdata[0];
                CFG_DRIVE_MAP: r_drive_map <= i_cfg_wdata[25:0];
                CFG_BUF_LIMIT: r_buf_limit <= i_cfg_wdata[15:0];
                CFG_TOK_LIMIT: r_tok_limit <= i_cfg_wdata[7:0];
                default:       r_trace     <= r_trace;
            endcase
        end
    end

    // Input buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hd_v <= 1'b0;
            r_sk_v <= 1'b0;
        end else if (load) begin
            if (r_sk_v) begin
                r_sk_v <= 1'b0;
            end else begin
                r_hd_v <= accept;
            end
        end else if (accept) begin
            if (!r_hd_v) begin
                r_hd_v <= 1'b1;
            end else begin
                r_sk_v <= 1'b1;
            end
        end
    end

    // Input buffer payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_sk_v) begin
                r_hd_ch   <= r_sk_ch;
                r_hd_last <= r_sk_last;
            end else begin
                r_hd_ch   <= i_ch;
                r_hd_last <= i_last;
            end
        end else if (accept) begin
            if (!r_hd_v) begin
                r_hd_ch   <= i_ch;
                r_hd_last <= i_last;
            end else begin
                r_sk_ch   <= i_ch;
                r_sk_last <= i_last;
            end
        end
    end

    // Scanner state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= ST_IDLE;
            r_prev <= CH_COMMA;
            r_wp   <= '0;
            r_sp   <= '0;
            r_tm   <= '0;
            r_syn  <= 1'b0;
            r_drv  <= 1'b0;
            r_badr <= 1'b0;
            r_badi <= '0;
            r_abt  <= 1'b0;
        end else if (load) begin
            r_scan <= n_scan;
            r_prev <= n_prev;
            r_wp   <= n_wp;
            r_sp   <= n_sp;
            r_tm   <= n_tm;
            r_syn  <= n_syn;
            r_drv  <= n_drv;
            r_badr <= n_badr;
            r_badi <= n_badi;
            r_abt  <= n_abt;
        end
    end

    // Result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (load) begin
            r_cnt <= n_cnt;
            r_idx <= '0;
        end else if (take_last) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (take) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int k = 0; k < RES_SLOTS; k++) begin
                r_res[k] <= n_res[k];
            end
        end
    end

    // Output beat
    assign o_kind            = r_res[r_idx].kind;
    assign o_out_byte        = r_res[r_idx].out_byte;
    assign o_position        = r_res[r_idx].position;
    assign o_token_ends      = r_res[r_idx].token_ends;
    assign o_token_start     = r_res[r_idx].token_start;
    assign o_status          = r_res[r_idx].status;
    assign o_token_count     = r_res[r_idx].token_count;
    assign o_bad_token_valid = r_res[r_idx].bad_valid;
    assign o_bad_token_index = r_res[r_idx].bad_index;
    assign o_last_result     = is_last_idx;

endmodule

// ===== tb/sv/command_line_token_splitter_tb.sv =====
module command_line_token_splitter_tb import cts_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 3000;   // cycles without any beat
    localparam int PRESS_LEN   = 150;    // long receiver hold-off

    // One expected or observed result beat
    typedef struct packed {
        t_res r;
        logic lst;
    } t_exp;

    // One argument character beat
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [1:0]            i_cfg_index = CFG_TRACE;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [7:0]            i_ch = CH_NUL;
    logic                  i_last = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_kind;
    logic [7:0]            o_out_byte;
    logic [15:0]           o_position;
    logic                  o_token_ends;
    logic [15:0]           o_token_start;
    logic [1:0]            o_status;
    logic [7:0]            o_token_count;
    logic                  o_bad_token_valid;
    logic [7:0]            o_bad_token_index;
    logic                  o_last_result;

    command_line_token_splitter dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_ch              (i_ch),
        .i_last            (i_last),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_kind            (o_kind),
        .o_out_byte        (o_out_byte),
        .o_position        (o_position),
        .o_token_ends      (o_token_ends),
        .o_token_start     (o_token_start),
        .o_status          (o_status),
        .o_token_count     (o_token_count),
        .o_bad_token_valid (o_bad_token_valid),
        .o_bad_token_index (o_bad_token_index),
        .o_last_result     (o_last_result)
    );

    always #5 i_clk = ~i_clk;

    // Register shadow
    logic        trace_on = 1'b0;
    logic [25:0] drives = '0;
    logic [15:0] buf_lim = BUF_LIMIT_RST;
    logic [7:0]  tok_lim = TOK_LIMIT_RST;

    // Scanner state of the predictor
    t_scan       scan_st = ST_IDLE;
    logic [7:0]  prev_ch = CH_COMMA;
    logic [15:0] wpos = '0;
    logic [15:0] tok_start = '0;
    logic [7:0]  ntok = '0;
    logic        syn_err = 1'b0;
    logic        drv_err = 1'b0;
    logic        bad_seen = 1'b0;
    logic [7:0]  bad_idx = '0;
    logic        aborted = 1'b0;

    t_char char_q[$];    // characters waiting to be sent
    t_exp  split_q[$];   // splitter results still to come

    t_char nxt;
    t_exp  seen;
    t_exp  want;
    int    in_gap = 0;
    int    out_hold = 0;
    int    press_asked = 0;
    int    press_done = 0;
    bit    calm = 1'b0;
    int    n_queued = 0;
    int    n_accepted = 0;
    int    n_cmds = 0;
    int    n_results = 0;
    int    n_status = 0;
    int    n_overflow = 0;
    int    n_settings = 1;
    int    n_bad = 0;
    int    idle_cycles = 0;

    // ---------------- predictor ----------------

    task automatic clear_cmd();
        scan_st   = ST_IDLE;
        prev_ch   = CH_COMMA;
        wpos      = '0;
        tok_start = '0;
        ntok      = '0;
        syn_err   = 1'b0;
        drv_err   = 1'b0;
        bad_seen  = 1'b0;
        bad_idx   = '0;
        aborted   = 1'b0;
    endtask

    task automatic put_byte(input logic [7:0] b, input logic ends, input logic [15:0] st);
        t_exp e;
        e = '0;
        e.r.kind        = KIND_BYTE;
        e.r.out_byte    = b;
        e.r.position    = wpos;
        e.r.token_ends  = ends;
        e.r.token_start = st;
        split_q.push_back(e);
        wpos = wpos + 16'd1;
    endtask

    // Terminator write; first token closed with a drive error pending is recorded
    task automatic close_token();
        if (!bad_seen && !syn_err && drv_err) begin
            bad_idx  = ntok;
            bad_seen = 1'b1;
        end
        put_byte(CH_NUL, 1'b1, tok_start);
        ntok      = ntok + 8'd1;
        scan_st   = ST_IDLE;
        tok_start = wpos;
    endtask

    function automatic logic drive_exists(input logic [7:0] d);
        logic [7:0] u;
        u = d;
        if (u >= CH_LO_A && u <= CH_LO_Z)
            u = u - CASE_GAP;
        if (u < CH_UP_A || u > CH_UP_Z)
            return 1'b0;
        return drives[u - CH_UP_A];
    endfunction

    task automatic scan_char(input logic [7:0] c);
        if (c == CH_NUL || c == CH_SPACE) begin
            if (scan_st == ST_ONE || scan_st == ST_WORD)
                close_token();
        end else if (c == CH_COMMA) begin
            if (scan_st == ST_ONE || scan_st == ST_WORD) begin
                close_token();
            end else if (scan_st == ST_SWITCH) begin
                syn_err = 1'b1;
                put_byte(c, 1'b0, '0);
                close_token();
            end
        end else if (c == CH_COLON && !trace_on) begin
            put_byte(c, 1'b0, '0);
            if (scan_st == ST_ONE) begin
                if (!drive_exists(prev_ch))
                    drv_err = 1'b1;
            end else begin
                syn_err = 1'b1;
            end
            close_token();
        end else if (c == CH_SLASH && !trace_on) begin
            // a switch right after a one-char token is dropped
            if (scan_st == ST_IDLE) begin
                put_byte(c, 1'b0, '0);
                scan_st = ST_SWITCH;
            end else if (scan_st == ST_WORD) begin
                close_token();
                put_byte(c, 1'b0, '0);
                scan_st = ST_SWITCH;
            end else if (scan_st == ST_SWITCH) begin
                syn_err = 1'b1;
                put_byte(c, 1'b0, '0);
                close_token();
            end
        end else begin
            put_byte(c, 1'b0, '0);
            scan_st = (scan_st == ST_IDLE) ? ST_ONE : ST_WORD;
        end
        prev_ch = c;
    endtask

    // Expected results of one accepted character
    task automatic split_char(input logic [7:0] c, input logic fin);
        int   base;
        t_exp e;
        base = split_q.size();
        if (!aborted) begin
            if ({16'd0, wpos} + 32'd2 >= {16'd0, buf_lim} ||
                {24'd0, ntok} + 32'd2 >= {24'd0, tok_lim})
                aborted = 1'b1;
            else
                scan_char(c);
        end
        if (fin) begin
            if (!aborted && scan_st == ST_SWITCH)
                close_token();
            e = '0;
            e.r.kind        = KIND_STATUS;
            e.r.status      = aborted ? STAT_OVERFLOW : syn_err ? STAT_SYNTAX :
                              drv_err ? STAT_DRIVE : STAT_OK;
            e.r.token_count = ntok;
            e.r.bad_valid   = bad_seen;
            e.r.bad_index   = bad_idx;
            split_q.push_back(e);
            clear_cmd();
        end
        if (split_q.size() > base) begin
            e = split_q.pop_back();
            e.lst = 1'b1;
            split_q.push_back(e);
        end
    endtask

    // ---------------- stimulus helpers ----------------

    function automatic int idle_len();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    task automatic add_char(input logic [7:0] c, input logic fin);
        t_char t;
        t.ch   = c;
        t.last = fin;
        char_q.push_back(t);
        n_queued++;
        if (fin)
            n_cmds++;
    endtask

    function automatic logic [7:0] letter();
        return ($urandom_range(0, 1) != 0) ? CH_UP_A + 8'($urandom_range(0, 25)) :
                                             CH_LO_A + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] word_char();
        return ($urandom_range(0, 4) == 0) ? 8'h30 + 8'($urandom_range(0, 9)) : letter();
    endfunction

    task automatic add_word(input int n);
        for (int i = 0; i < n; i++)
            add_char(word_char(), 1'b0);
    endtask

    // One command of well-formed pieces with some noise mixed in
    task automatic add_command();
        int nargs;
        int npieces;
        logic [7:0] punct[5];
        punct = '{CH_COLON, CH_SLASH, CH_COMMA, CH_SPACE, CH_NUL};
        nargs = $urandom_range(1, 3);
        for (int a = 0; a < nargs; a++) begin
            npieces = $urandom_range(1, 4);
            for (int p = 0; p < npieces; p++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: add_word($urandom_range(1, 6));
                    3: add_char(letter(), 1'b0);
                    4: begin
                        add_char(($urandom_range(0, 5) == 0) ? word_char() : letter(), 1'b0);
                        add_char(CH_COLON, 1'b0);
                        if ($urandom_range(0, 2) == 0)
                            add_word($urandom_range(1, 4));
                    end
                    5: begin
                        add_char(CH_SLASH, 1'b0);
                        add_word($urandom_range(0, 3));
                    end
                    6: add_char(($urandom_range(0, 1) != 0) ? CH_SPACE : CH_COMMA, 1'b0);
                    7: begin
                        add_word($urandom_range(1, 3));
                        add_char(CH_SLASH, 1'b0);
                        add_word($urandom_range(1, 3));
                    end
                    8: add_char(punct[$urandom_range(0, 4)], 1'b0);
                    default: add_char(8'($urandom_range(0, 255)), 1'b0);
                endcase
                if (p < npieces - 1 && $urandom_range(0, 1) != 0)
                    add_char(($urandom_range(0, 2) != 0) ? CH_SPACE : CH_COMMA, 1'b0);
            end
            if (a < nargs - 1)
                add_char(CH_NUL, 1'b0);
            else if ($urandom_range(0, 7) == 0)
                add_char(8'($urandom_range(1, 255)), 1'b1);
            else
                add_char(CH_NUL, 1'b1);
        end
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_TRACE:     trace_on = val[0];
            CFG_DRIVE_MAP: drives   = val[25:0];
            CFG_BUF_LIMIT: buf_lim  = val[15:0];
            CFG_TOK_LIMIT: tok_lim  = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic t, input logic [25:0] map,
                              input logic [15:0] bl, input logic [7:0] tl);
        cfg_write(CFG_TRACE, CFG_DATA_W'(t));
        cfg_write(CFG_DRIVE_MAP, map);
        cfg_write(CFG_BUF_LIMIT, CFG_DATA_W'(bl));
        cfg_write(CFG_TOK_LIMIT, CFG_DATA_W'(tl));
        i_cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    // Wait until every character is taken and every result seen, then let
    // the pipeline empty of characters that give no result
    task automatic settle();
        while (n_accepted != n_queued || split_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic random_phase(input int target, input bit press);
        int start;
        start = n_queued;
        if (press)
            press_asked++;
        while (n_queued - start < target)
            add_command();
        settle();
    endtask

    task automatic report_bad(input string what, input t_exp w, input t_exp s);
        n_bad++;
        if (n_bad <= 10) begin
            $display("%0t: %s", $realtime, what);
            $write("  exp kind=%0d byte=%02h pos=%0d end=%0d start=%0d",
                   w.r.kind, w.r.out_byte, w.r.position, w.r.token_ends, w.r.token_start);
            $display(" st=%0d cnt=%0d bad=%0d/%0d last=%0d",
                     w.r.status, w.r.token_count, w.r.bad_valid, w.r.bad_index, w.lst);
            $write("  got kind=%0d byte=%02h pos=%0d end=%0d start=%0d",
                   s.r.kind, s.r.out_byte, s.r.position, s.r.token_ends, s.r.token_start);
            $display(" st=%0d cnt=%0d bad=%0d/%0d last=%0d",
                     s.r.status, s.r.token_count, s.r.bad_valid, s.r.bad_index, s.lst);
        end
    endtask

    // ---------------- driver ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                split_char(i_ch, i_last);
                n_accepted++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (char_q.size() > 0) begin
                    nxt = char_q.pop_front();
                    i_ch       <= nxt.ch;
                    i_last     <= nxt.last;
                    i_in_valid <= 1'b1;
                    in_gap = (calm || $urandom_range(0, 3) != 0) ? 0 : idle_len();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- receiver ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (press_done != press_asked) begin
            press_done++;
            out_hold = PRESS_LEN;
            i_out_ready <= 1'b0;
        end else if (out_hold > 0) begin
            out_hold--;
            i_out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            out_hold = idle_len() - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ---------------- monitor ----------------

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen.r.kind        = o_kind;
            seen.r.out_byte    = o_out_byte;
            seen.r.position    = o_position;
            seen.r.token_ends  = o_token_ends;
            seen.r.token_start = o_token_start;
            seen.r.status      = o_status;
            seen.r.token_count = o_token_count;
            seen.r.bad_valid   = o_bad_token_valid;
            seen.r.bad_index   = o_bad_token_index;
            seen.lst           = o_last_result;
            n_results++;
            if (seen.r.kind == KIND_STATUS) begin
                n_status++;
                if (seen.r.status == STAT_OVERFLOW)
                    n_overflow++;
            end
            if (split_q.size() == 0) begin
                report_bad("result beat with nothing expected", '0, seen);
            end else begin
                want = split_q.pop_front();
                if (seen !== want)
                    report_bad("result beat mismatch", want, seen);
            end
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("no beat for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, split_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset registers, every drive missing
        add_char("x", 1'b0);          // lower-case drive letter, not in map
        add_char(CH_COLON, 1'b0);
        add_char(CH_SPACE, 1'b0);     // space while idle
        add_char(CH_SLASH, 1'b0);     // switch from idle
        add_char(CH_SPACE, 1'b0);     // space inside a switch is ignored
        add_char(CH_NUL, 1'b0);       // so is an argument end
        add_char(CH_COMMA, 1'b0);     // comma inside a switch
        add_char("a", 1'b0);
        add_char(CH_SLASH, 1'b0);     // switch after a one-char token, dropped
        add_char("b", 1'b0);
        add_char("c", 1'b0);
        add_char(CH_SLASH, 1'b0);     // switch after a word
        add_char(CH_SLASH, 1'b0);     // switch inside a switch
        add_char(CH_COLON, 1'b0);     // colon while idle
        add_char(8'hff, 1'b0);
        add_char(8'h80, 1'b0);
        add_char(8'h01, 1'b0);
        add_char(CH_NUL, 1'b1);
        add_char(CH_SLASH, 1'b0);     // switch still open when the command ends
        add_char("z", 1'b1);          // end flagged on a real character
        settle();

        // Directed: smallest buffer, overflow on the second character
        cfg_write(CFG_BUF_LIMIT, CFG_DATA_W'(3));
        i_cfg_wr_en <= 1'b0;
        n_settings++;
        add_char("k", 1'b0);
        add_char("m", 1'b0);
        add_char(CH_NUL, 1'b1);
        settle();

        // Random commands over a range of register settings
        set_config(1'b0, 26'h3ffffff, 16'hffff, 8'hff);
        random_phase(25, 1'b1);

        calm = 1'b1;
        set_config(1'b1, 26'($urandom), BUF_LIMIT_RST, TOK_LIMIT_RST);
        random_phase(15, 1'b0);
        calm = 1'b0;

        set_config(1'b0, 26'($urandom), 16'd20, 8'd8);
        random_phase(20, 1'b0);

        set_config(1'b0, 26'h0, 16'd64, 8'd3);
        random_phase(15, 1'b0);

        set_config(1'b0, 26'($urandom), 16'($urandom_range(3, 80)),
                   8'($urandom_range(3, 255)));
        random_phase(25, 1'b1);

        set_config(1'b1, 26'($urandom), 16'd12, 8'd5);
        random_phase(15, 1'b0);

        $display("Sent %0d characters in %0d commands over %0d register settings.",
                 n_accepted, n_cmds, n_settings);
        $display("Checked %0d result beats, %0d status beats (%0d overflow), %0d errors.",
                 n_results, n_status, n_overflow, n_bad);
        if (n_bad == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
sv/cts_pkg.sv
sv/command_line_token_splitter.sv
tb/sv/command_line_token_splitter_tb.sv
